>>> sv/qocm_pkg.sv
// Shared types and constants of the quaternion orthographic chart map.
package qocm_pkg;

    localparam int QW        = 24;                  // Q3.20 word
    localparam int RAD_W     = 48;                  // radicand of the square root
    localparam int ROOT_W    = 25;                  // square root result
    localparam int NUM_W     = 45;                  // dividend of the rescale
    localparam int REM_W     = 26;                  // partial remainder
    localparam int SQ_STEPS  = 24;                  // root bits, one per stage
    localparam int DIV_STEPS = 22;                  // quotient bits, one per stage
    localparam int QUO_W     = DIV_STEPS;
    localparam int VW        = 25;                  // multiplier operand
    localparam int PROD_W    = QW + VW;
    localparam int SUM_W     = PROD_W + 3;
    localparam int SEL_STAGE = 3 + SQ_STEPS + 1 + DIV_STEPS;
    localparam int NST       = SEL_STAGE + 4;       // pipeline depth
    localparam int FRAC_CHART = 19;                 // shift for chart results
    localparam int FRAC_QUAT  = 21;                 // shift for quaternion results
    localparam logic [RAD_W-1:0] FOUR = RAD_W'(1) << 42;   // 4.0 with 40 fraction bits
    localparam logic signed [QW-1:0] Q_MAX = {1'b0, {(QW-1){1'b1}}};
    localparam logic signed [QW-1:0] Q_MIN = {1'b1, {(QW-1){1'b0}}};

    typedef logic signed [QW-1:0] q_t;

    typedef enum logic
    {
        OP_TO_CHART = 1'b0,
        OP_TO_QUAT  = 1'b1
    } op_t;

    typedef struct packed
    {
        op_t  op;
        logic clamped;
        q_t   mw;
        q_t   mx;
        q_t   my;
        q_t   mz;
        q_t   a;
        q_t   b;
        q_t   c;
        q_t   d;
    } carry_t;

endpackage

>>> sv/qocm_in_if.sv
// Input channel: operation, mean quaternion and four operands.
interface qocm_in_if;
    logic                 valid;
    logic                 ready;
    logic                 operation;
    qocm_pkg::q_t         mean_w;
    qocm_pkg::q_t         mean_x;
    qocm_pkg::q_t         mean_y;
    qocm_pkg::q_t         mean_z;
    qocm_pkg::q_t         in_a;
    qocm_pkg::q_t         in_b;
    qocm_pkg::q_t         in_c;
    qocm_pkg::q_t         in_d;

    modport source
    (
        output valid, operation, mean_w, mean_x, mean_y, mean_z, in_a, in_b, in_c, in_d,
        input  ready
    );
    modport sink
    (
        input  valid, operation, mean_w, mean_x, mean_y, mean_z, in_a, in_b, in_c, in_d,
        output ready
    );
endinterface

>>> sv/qocm_out_if.sv
// Output channel: four result components and the clamp flag.
interface qocm_out_if;
    logic                 valid;
    logic                 ready;
    qocm_pkg::q_t         out_a;
    qocm_pkg::q_t         out_b;
    qocm_pkg::q_t         out_c;
    qocm_pkg::q_t         out_d;
    logic                 norm_clamped;

    modport source
    (
        output valid, out_a, out_b, out_c, out_d, norm_clamped,
        input  ready
    );
    modport sink
    (
        input  valid, out_a, out_b, out_c, out_d, norm_clamped,
        output ready
    );
endinterface

>>> sv/quaternion_orthographic_chart_map_top.sv
// Quaternion orthographic chart map: 54-stage pipeline, one item per cycle.
// Accepts one item every cycle while the output side does not stall, and returns one result
// per item, in order. The depth is set by the square root (one root bit per stage, 24 stages)
// and the rescale divider (one quotient bit per stage, 22 stages); every item passes through
// both. A stall at the output freezes the whole pipeline, so ready follows the output side
// within the same cycle.
module quaternion_orthographic_chart_map_top
(
    input  logic             clk,
    input  logic             rst_n,
    qocm_in_if.sink          cmd,
    qocm_out_if.source       rsp
);

    logic                       adv;
    logic [qocm_pkg::NST-1:0]   vld_reg;

    // front stages
    qocm_pkg::carry_t           c0_reg;
    qocm_pkg::carry_t           c1_reg;
    qocm_pkg::carry_t           c2_reg;
    qocm_pkg::carry_t           c2_next;
    logic [qocm_pkg::RAD_W-1:0] sq_reg [3];
    logic [qocm_pkg::RAD_W-1:0] ssum;
    logic [qocm_pkg::RAD_W-1:0] rad_reg;
    logic                       clamp_next;

    // square root stages
    logic [qocm_pkg::RAD_W-1:0] sx_reg [qocm_pkg::SQ_STEPS];
    logic [qocm_pkg::RAD_W-1:0] sr_reg [qocm_pkg::SQ_STEPS];
    qocm_pkg::carry_t           sc_reg [qocm_pkg::SQ_STEPS];

    // divider prep and stages
    logic [qocm_pkg::ROOT_W-1:0] root;
    logic [qocm_pkg::QW-1:0]     mag [3];
    logic [qocm_pkg::NUM_W-1:0]  pn_reg [3];
    logic [qocm_pkg::ROOT_W-1:0] proot_reg;
    qocm_pkg::carry_t            pc_reg;
    logic [qocm_pkg::NUM_W-1:0]  dn_reg [qocm_pkg::DIV_STEPS][3];
    logic [qocm_pkg::REM_W-1:0]  dr_reg [qocm_pkg::DIV_STEPS][3];
    logic [qocm_pkg::QUO_W-1:0]  dq_reg [qocm_pkg::DIV_STEPS][3];
    logic [qocm_pkg::ROOT_W-1:0] droot_reg [qocm_pkg::DIV_STEPS];
    qocm_pkg::carry_t            dc_reg [qocm_pkg::DIV_STEPS];

    // back stages
    logic signed [qocm_pkg::VW-1:0]     v_next [4];
    logic signed [qocm_pkg::VW-1:0]     v_reg [4];
    qocm_pkg::carry_t                   vc_reg;
    logic signed [qocm_pkg::PROD_W-1:0] p_reg [4][4];
    logic                               pop_reg;
    logic                               pcl_reg;
    logic signed [qocm_pkg::SUM_W-1:0]  dd_next [4];
    logic signed [qocm_pkg::SUM_W-1:0]  dd_reg [4];
    logic                               neg_reg;
    logic                               sop_reg;
    logic                               scl_reg;
    qocm_pkg::q_t                       out_reg [4];
    logic                               ocl_reg;
    logic                               oop_reg;

    function automatic logic signed [qocm_pkg::SUM_W-1:0] ext
    (
        input logic signed [qocm_pkg::PROD_W-1:0] p
    );
        return {{(qocm_pkg::SUM_W-qocm_pkg::PROD_W){p[qocm_pkg::PROD_W-1]}}, p};
    endfunction

    // Round half up at the given shift, then saturate.
    function automatic qocm_pkg::q_t rnd_sat
    (
        input logic signed [qocm_pkg::SUM_W-1:0] v,
        input logic                              op
    );
        logic signed [qocm_pkg::SUM_W-1:0] t;
        logic signed [qocm_pkg::SUM_W-1:0] r;
        if (op == qocm_pkg::OP_TO_CHART)
        begin
            t = v + (qocm_pkg::SUM_W'(1) <<< (qocm_pkg::FRAC_CHART - 1));
            r = t >>> qocm_pkg::FRAC_CHART;
        end
        else
        begin
            t = v + (qocm_pkg::SUM_W'(1) <<< (qocm_pkg::FRAC_QUAT - 1));
            r = t >>> qocm_pkg::FRAC_QUAT;
        end
        if (r > qocm_pkg::SUM_W'(qocm_pkg::Q_MAX))
            return qocm_pkg::Q_MAX;
        else if (r < qocm_pkg::SUM_W'(qocm_pkg::Q_MIN))
            return qocm_pkg::Q_MIN;
        else
            return r[qocm_pkg::QW-1:0];
    endfunction

    assign adv       = !vld_reg[qocm_pkg::NST-1] || rsp.ready;
    assign cmd.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[qocm_pkg::NST-2:0], cmd.valid};
    end

    // input register, squares, radicand
    always_comb
    begin
        ssum       = sq_reg[0] + sq_reg[1] + sq_reg[2];
        clamp_next = ssum > qocm_pkg::FOUR;
        c2_next         = c1_reg;
        c2_next.clamped = clamp_next && (c1_reg.op == qocm_pkg::OP_TO_QUAT);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c0_reg.op      <= qocm_pkg::op_t'(cmd.operation);
            c0_reg.clamped <= 1'b0;
            c0_reg.mw      <= cmd.mean_w;
            c0_reg.mx      <= cmd.mean_x;
            c0_reg.my      <= cmd.mean_y;
            c0_reg.mz      <= cmd.mean_z;
            c0_reg.a       <= cmd.in_a;
            c0_reg.b       <= cmd.in_b;
            c0_reg.c       <= cmd.in_c;
            c0_reg.d       <= cmd.in_d;
            sq_reg[0]      <= qocm_pkg::RAD_W'(c0_reg.a * c0_reg.a);
            sq_reg[1]      <= qocm_pkg::RAD_W'(c0_reg.b * c0_reg.b);
            sq_reg[2]      <= qocm_pkg::RAD_W'(c0_reg.c * c0_reg.c);
            c1_reg         <= c0_reg;
            rad_reg        <= clamp_next ? ssum : qocm_pkg::FOUR - ssum;
            c2_reg         <= c2_next;
        end
    end

    // square root, one result bit per stage
    for (genvar k = 0; k < qocm_pkg::SQ_STEPS; k++)
    begin : g_sqrt
        localparam logic [qocm_pkg::RAD_W-1:0] BIT =
            qocm_pkg::RAD_W'(1) << (2 * (qocm_pkg::SQ_STEPS - 1 - k));
        logic [qocm_pkg::RAD_W-1:0] x_in;
        logic [qocm_pkg::RAD_W-1:0] r_in;
        qocm_pkg::carry_t           c_in;
        logic [qocm_pkg::RAD_W:0]   t;
        logic [qocm_pkg::RAD_W-1:0] x_next;
        logic [qocm_pkg::RAD_W-1:0] r_next;

        if (k == 0)
        begin : g_first
            assign x_in = rad_reg;
            assign r_in = '0;
            assign c_in = c2_reg;
        end
        else
        begin : g_rest
            assign x_in = sx_reg[k-1];
            assign r_in = sr_reg[k-1];
            assign c_in = sc_reg[k-1];
        end

        always_comb
        begin
            t = {1'b0, r_in} + {1'b0, BIT};
            if ({1'b0, x_in} >= t)
            begin
                x_next = x_in - t[qocm_pkg::RAD_W-1:0];
                r_next = (r_in >> 1) + BIT;
            end
            else
            begin
                x_next = x_in;
                r_next = r_in >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sx_reg[k] <= x_next;
                sr_reg[k] <= r_next;
                sc_reg[k] <= c_in;
            end
        end
    end

    // dividend of the rescale: |e| * 2^21 plus half the norm
    always_comb
    begin
        root   = sr_reg[qocm_pkg::SQ_STEPS-1][qocm_pkg::ROOT_W-1:0];
        mag[0] = sc_reg[qocm_pkg::SQ_STEPS-1].a[qocm_pkg::QW-1]
               ? qocm_pkg::QW'(~sc_reg[qocm_pkg::SQ_STEPS-1].a + 1'b1)
               : qocm_pkg::QW'(sc_reg[qocm_pkg::SQ_STEPS-1].a);
        mag[1] = sc_reg[qocm_pkg::SQ_STEPS-1].b[qocm_pkg::QW-1]
               ? qocm_pkg::QW'(~sc_reg[qocm_pkg::SQ_STEPS-1].b + 1'b1)
               : qocm_pkg::QW'(sc_reg[qocm_pkg::SQ_STEPS-1].b);
        mag[2] = sc_reg[qocm_pkg::SQ_STEPS-1].c[qocm_pkg::QW-1]
               ? qocm_pkg::QW'(~sc_reg[qocm_pkg::SQ_STEPS-1].c + 1'b1)
               : qocm_pkg::QW'(sc_reg[qocm_pkg::SQ_STEPS-1].c);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
                pn_reg[i] <= {mag[i], {qocm_pkg::FRAC_QUAT{1'b0}}}
                           + qocm_pkg::NUM_W'(root >> 1);
            proot_reg <= root;
            pc_reg    <= sc_reg[qocm_pkg::SQ_STEPS-1];
        end
    end

    // restoring divider, one quotient bit per stage, three lanes
    for (genvar j = 0; j < qocm_pkg::DIV_STEPS; j++)
    begin : g_div
        logic [qocm_pkg::ROOT_W-1:0] n_in;
        qocm_pkg::carry_t            c_in;
        logic [qocm_pkg::NUM_W-1:0]  num_in [3];
        logic [qocm_pkg::REM_W-1:0]  r_in [3];
        logic [qocm_pkg::QUO_W-1:0]  q_in [3];
        logic [qocm_pkg::REM_W-1:0]  t [3];
        logic [qocm_pkg::REM_W-1:0]  r_next [3];
        logic [qocm_pkg::QUO_W-1:0]  q_next [3];

        if (j == 0)
        begin : g_first
            assign n_in = proot_reg;
            assign c_in = pc_reg;
            for (genvar i = 0; i < 3; i++)
            begin : g_lane
                assign num_in[i] = pn_reg[i];
                assign r_in[i]   = qocm_pkg::REM_W'(pn_reg[i][qocm_pkg::NUM_W-1:qocm_pkg::DIV_STEPS]);
                assign q_in[i]   = '0;
            end
        end
        else
        begin : g_rest
            assign n_in = droot_reg[j-1];
            assign c_in = dc_reg[j-1];
            for (genvar i = 0; i < 3; i++)
            begin : g_lane
                assign num_in[i] = dn_reg[j-1][i];
                assign r_in[i]   = dr_reg[j-1][i];
                assign q_in[i]   = dq_reg[j-1][i];
            end
        end

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                t[i] = {r_in[i][qocm_pkg::REM_W-2:0], num_in[i][qocm_pkg::DIV_STEPS-1-j]};
                if (t[i] >= qocm_pkg::REM_W'(n_in))
                begin
                    r_next[i] = t[i] - qocm_pkg::REM_W'(n_in);
                    q_next[i] = {q_in[i][qocm_pkg::QUO_W-2:0], 1'b1};
                end
                else
                begin
                    r_next[i] = t[i];
                    q_next[i] = {q_in[i][qocm_pkg::QUO_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    dn_reg[j][i] <= num_in[i];
                    dr_reg[j][i] <= r_next[i];
                    dq_reg[j][i] <= q_next[i];
                end
                droot_reg[j] <= n_in;
                dc_reg[j]    <= c_in;
            end
        end
    end

    // pick the multiplier operands: the quaternion itself, or (w, e)
    always_comb
    begin
        qocm_pkg::carry_t c;
        logic [qocm_pkg::QUO_W-1:0] q [3];
        logic signs [3];
        c        = dc_reg[qocm_pkg::DIV_STEPS-1];
        q[0]     = dq_reg[qocm_pkg::DIV_STEPS-1][0];
        q[1]     = dq_reg[qocm_pkg::DIV_STEPS-1][1];
        q[2]     = dq_reg[qocm_pkg::DIV_STEPS-1][2];
        signs[0] = c.a[qocm_pkg::QW-1];
        signs[1] = c.b[qocm_pkg::QW-1];
        signs[2] = c.c[qocm_pkg::QW-1];
        if (c.op == qocm_pkg::OP_TO_CHART)
        begin
            v_next[0] = qocm_pkg::VW'(c.a);
            v_next[1] = qocm_pkg::VW'(c.b);
            v_next[2] = qocm_pkg::VW'(c.c);
            v_next[3] = qocm_pkg::VW'(c.d);
        end
        else if (c.clamped)
        begin
            v_next[0] = '0;
            for (int i = 0; i < 3; i++)
                v_next[i+1] = signs[i] ? -$signed({3'b000, q[i]}) : $signed({3'b000, q[i]});
        end
        else
        begin
            v_next[0] = $signed(qocm_pkg::VW'(droot_reg[qocm_pkg::DIV_STEPS-1]));
            v_next[1] = qocm_pkg::VW'(c.a);
            v_next[2] = qocm_pkg::VW'(c.b);
            v_next[3] = qocm_pkg::VW'(c.c);
        end
    end

    // Quaternion products: mean times operand. The chart map uses the conjugate,
    // which flips the sign of every term that holds mx, my or mz.
    always_comb
    begin
        logic signed [qocm_pkg::SUM_W-1:0] t1;
        logic signed [qocm_pkg::SUM_W-1:0] t2;
        logic signed [qocm_pkg::SUM_W-1:0] t3;
        t1 = ext(p_reg[1][0]) + ext(p_reg[2][3]) - ext(p_reg[3][2]);
        t2 = ext(p_reg[2][0]) + ext(p_reg[3][1]) - ext(p_reg[1][3]);
        t3 = ext(p_reg[3][0]) + ext(p_reg[1][2]) - ext(p_reg[2][1]);
        if (pop_reg == qocm_pkg::OP_TO_CHART)
        begin
            dd_next[0] = ext(p_reg[0][1]) - t1;
            dd_next[1] = ext(p_reg[0][2]) - t2;
            dd_next[2] = ext(p_reg[0][3]) - t3;
            dd_next[3] = ext(p_reg[0][0]) + ext(p_reg[1][1])
                       + ext(p_reg[2][2]) + ext(p_reg[3][3]);
        end
        else
        begin
            dd_next[0] = ext(p_reg[0][0]) - ext(p_reg[1][1])
                       - ext(p_reg[2][2]) - ext(p_reg[3][3]);
            dd_next[1] = ext(p_reg[0][1]) + t1;
            dd_next[2] = ext(p_reg[0][2]) + t2;
            dd_next[3] = ext(p_reg[0][3]) + t3;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 4; i++)
                v_reg[i] <= v_next[i];
            vc_reg <= dc_reg[qocm_pkg::DIV_STEPS-1];

            p_reg[0][0] <= vc_reg.mw * v_reg[0];
            p_reg[0][1] <= vc_reg.mw * v_reg[1];
            p_reg[0][2] <= vc_reg.mw * v_reg[2];
            p_reg[0][3] <= vc_reg.mw * v_reg[3];
            p_reg[1][0] <= vc_reg.mx * v_reg[0];
            p_reg[1][1] <= vc_reg.mx * v_reg[1];
            p_reg[1][2] <= vc_reg.mx * v_reg[2];
            p_reg[1][3] <= vc_reg.mx * v_reg[3];
            p_reg[2][0] <= vc_reg.my * v_reg[0];
            p_reg[2][1] <= vc_reg.my * v_reg[1];
            p_reg[2][2] <= vc_reg.my * v_reg[2];
            p_reg[2][3] <= vc_reg.my * v_reg[3];
            p_reg[3][0] <= vc_reg.mz * v_reg[0];
            p_reg[3][1] <= vc_reg.mz * v_reg[1];
            p_reg[3][2] <= vc_reg.mz * v_reg[2];
            p_reg[3][3] <= vc_reg.mz * v_reg[3];
            pop_reg     <= vc_reg.op;
            pcl_reg     <= vc_reg.clamped;

            for (int i = 0; i < 4; i++)
                dd_reg[i] <= dd_next[i];
            // negate the chart point when the scalar part is below zero
            neg_reg <= (pop_reg == qocm_pkg::OP_TO_CHART) && dd_next[3][qocm_pkg::SUM_W-1];
            sop_reg <= pop_reg;
            scl_reg <= pcl_reg;

            if (sop_reg == qocm_pkg::OP_TO_CHART)
            begin
                for (int i = 0; i < 3; i++)
                    out_reg[i] <= rnd_sat(neg_reg ? -dd_reg[i] : dd_reg[i], sop_reg);
                out_reg[3] <= '0;
            end
            else
            begin
                for (int i = 0; i < 4; i++)
                    out_reg[i] <= rnd_sat(dd_reg[i], sop_reg);
            end
            ocl_reg <= scl_reg;
            oop_reg <= sop_reg;
        end
    end

    assign rsp.valid        = vld_reg[qocm_pkg::NST-1];
    assign rsp.out_a        = out_reg[0];
    assign rsp.out_b        = out_reg[1];
    assign rsp.out_c        = out_reg[2];
    assign rsp.out_d        = out_reg[3];
    assign rsp.norm_clamped = ocl_reg;

    a_chart_result: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (oop_reg == qocm_pkg::OP_TO_CHART) |-> (out_reg[3] == '0) && !ocl_reg)
        else $error("chart result with nonzero fourth component or clamp flag");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during a stall");

    a_clamp_root: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[qocm_pkg::SEL_STAGE-1] && dc_reg[qocm_pkg::DIV_STEPS-1].clamped
        |-> droot_reg[qocm_pkg::DIV_STEPS-1] >= (qocm_pkg::ROOT_W'(1) << 21))
        else $error("clamped item with a norm below two");

    a_clamp_quot: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[qocm_pkg::SEL_STAGE-1] && dc_reg[qocm_pkg::DIV_STEPS-1].clamped
        |-> (dq_reg[qocm_pkg::DIV_STEPS-1][0] <= (qocm_pkg::QUO_W'(1) << 21))
         && (dq_reg[qocm_pkg::DIV_STEPS-1][1] <= (qocm_pkg::QUO_W'(1) << 21))
         && (dq_reg[qocm_pkg::DIV_STEPS-1][2] <= (qocm_pkg::QUO_W'(1) << 21)))
        else $error("rescaled coordinate above two");

endmodule

>>> tb/tb_quaternion_orthographic_chart_map_top.sv
// Testbench for the quaternion orthographic chart map: predicts each result and checks it.
`timescale 1ns / 100ps

class chart_scoreboard;
    typedef struct
    {
        logic [23:0] a;
        logic [23:0] b;
        logic [23:0] c;
        logic [23:0] d;
        logic        clamped;
    } chart_result_t;

    chart_result_t pending[$];
    int            errors = 0;

    static function logic [23:0] round_clip(longint v, int n);
        longint r;
        r = (v + (longint'(1) << (n - 1))) >>> n;
        if (r > 8388607)
            r = 8388607;
        if (r < -8388608)
            r = -8388608;
        return r[23:0];
    endfunction

    static function longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = longint'(1) << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function void note_item(logic op, qocm_pkg::q_t mw_i, qocm_pkg::q_t mx_i,
                            qocm_pkg::q_t my_i, qocm_pkg::q_t mz_i, qocm_pkg::q_t a_i,
                            qocm_pkg::q_t b_i, qocm_pkg::q_t c_i, qocm_pkg::q_t d_i);
        longint mw, mx, my, mz, a, b, c, d;
        longint d0, d1, d2, d3, w;
        longint e[3];
        longint unsigned s, n, mag, q;
        chart_result_t r;
        mw = mw_i; mx = mx_i; my = my_i; mz = mz_i;
        a = a_i; b = b_i; c = c_i; d = d_i;
        if (op == qocm_pkg::OP_TO_CHART)
        begin
            d0 = mw * a + mx * b + my * c + mz * d;
            d1 = mw * b - a * mx - my * d + mz * c;
            d2 = mw * c - a * my - mz * b + mx * d;
            d3 = mw * d - a * mz - mx * c + my * b;
            if (d0 < 0)
            begin
                d1 = -d1; d2 = -d2; d3 = -d3;
            end
            r.a = round_clip(d1, 19);
            r.b = round_clip(d2, 19);
            r.c = round_clip(d3, 19);
            r.d = '0;
            r.clamped = 1'b0;
        end
        else
        begin
            s = a * a + b * b + c * c;
            e[0] = a; e[1] = b; e[2] = c;
            r.clamped = s > (longint'(1) << 42);
            if (r.clamped)
            begin
                n = int_sqrt(s);
                for (int i = 0; i < 3; i++)
                begin
                    mag = (e[i] < 0 ? -e[i] : e[i]) << 21;
                    q = (mag + n / 2) / n;
                    e[i] = e[i] < 0 ? -longint'(q) : longint'(q);
                end
                w = 0;
            end
            else
                w = int_sqrt((longint'(1) << 42) - s);
            r.a = round_clip(mw * w - mx * e[0] - my * e[1] - mz * e[2], 21);
            r.b = round_clip(mw * e[0] + w * mx + my * e[2] - mz * e[1], 21);
            r.c = round_clip(mw * e[1] + w * my + mz * e[0] - mx * e[2], 21);
            r.d = round_clip(mw * e[2] + w * mz + mx * e[1] - my * e[0], 21);
        end
        pending.push_back(r);
    endfunction

    function void check_result(logic [23:0] a, logic [23:0] b, logic [23:0] c,
                               logic [23:0] d, logic clamped);
        chart_result_t x;
        if (pending.size() == 0)
        begin
            $error("result with no item outstanding");
            errors++;
            return;
        end
        x = pending.pop_front();
        if (a !== x.a) begin $error("out_a expected %h got %h", x.a, a); errors++; end
        if (b !== x.b) begin $error("out_b expected %h got %h", x.b, b); errors++; end
        if (c !== x.c) begin $error("out_c expected %h got %h", x.c, c); errors++; end
        if (d !== x.d) begin $error("out_d expected %h got %h", x.d, d); errors++; end
        if (clamped !== x.clamped)
        begin
            $error("norm_clamped expected %b got %b", x.clamped, clamped);
            errors++;
        end
    endfunction
endclass

module tb_quaternion_orthographic_chart_map_top;

    localparam int IDLE_PCT  = 34;
    localparam int WDOG_MAX  = 20000;

    logic clk;
    logic rst_n;
    qocm_in_if  cmd();
    qocm_out_if rsp();

    chart_scoreboard sb;
    bit   steady;           // no idling on either side
    bit   hold_rsp;         // long output hold-off
    int   quiet_cycles;

    quaternion_orthographic_chart_map_top uut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd.sink),
        .rsp   (rsp.source)
    );

    always #10 clk = ~clk;

    // Note accepted items and check results at the same edge.
    always @(posedge clk)
    begin
        if (rst_n && cmd.valid && cmd.ready)
            sb.note_item(cmd.operation, cmd.mean_w, cmd.mean_x, cmd.mean_y, cmd.mean_z,
                         cmd.in_a, cmd.in_b, cmd.in_c, cmd.in_d);
        if (rst_n && rsp.valid && rsp.ready)
            sb.check_result(rsp.out_a, rsp.out_b, rsp.out_c, rsp.out_d, rsp.norm_clamped);
    end

    always @(posedge clk)
    begin
        if (hold_rsp)
            rsp.ready <= 1'b0;
        else
            rsp.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_MAX)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic qocm_pkg::q_t pick_word();
        case ($urandom_range(7))
            0: return qocm_pkg::Q_MAX;
            1: return qocm_pkg::Q_MIN;
            2: return 24'sd0;
            3: return qocm_pkg::q_t'($urandom_range(2097152) - 1048576);
            4: return qocm_pkg::q_t'($urandom_range(4194304) - 2097152);
            default: return qocm_pkg::q_t'($urandom);
        endcase
    endfunction

    // Drop valid while idling; keep it high from one item straight into the next.
    task automatic send_item(logic op, qocm_pkg::q_t mw, qocm_pkg::q_t mx,
                             qocm_pkg::q_t my, qocm_pkg::q_t mz, qocm_pkg::q_t a,
                             qocm_pkg::q_t b, qocm_pkg::q_t c, qocm_pkg::q_t d);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            cmd.valid <= 1'b0;
            @(posedge clk);
        end
        cmd.valid     <= 1'b1;
        cmd.operation <= op;
        cmd.mean_w <= mw; cmd.mean_x <= mx; cmd.mean_y <= my; cmd.mean_z <= mz;
        cmd.in_a <= a; cmd.in_b <= b; cmd.in_c <= c; cmd.in_d <= d;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
    endtask

    task automatic send_random(logic op);
        // near-unit quaternions most of the time
        if ($urandom_range(3) != 0)
            send_item(op, qocm_pkg::q_t'($urandom_range(2097152) - 1048576),
                      qocm_pkg::q_t'($urandom_range(1048576) - 524288),
                      qocm_pkg::q_t'($urandom_range(1048576) - 524288),
                      qocm_pkg::q_t'($urandom_range(1048576) - 524288),
                      qocm_pkg::q_t'($urandom_range(2097152) - 1048576),
                      qocm_pkg::q_t'($urandom_range(2097152) - 1048576),
                      qocm_pkg::q_t'($urandom_range(2097152) - 1048576),
                      qocm_pkg::q_t'($urandom_range(2097152) - 1048576));
        else
            send_item(op, pick_word(), pick_word(), pick_word(), pick_word(),
                      pick_word(), pick_word(), pick_word(), pick_word());
    endtask

    task automatic drain();
        cmd.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        qocm_pkg::q_t one;
        one = 24'sd1048576;
        sb = new();
        clk = 1'b0;
        rst_n = 1'b0;
        steady = 1'b0;
        hold_rsp = 1'b0;
        quiet_cycles = 0;
        cmd.valid = 1'b0;
        cmd.operation = qocm_pkg::OP_TO_CHART;
        cmd.mean_w = '0; cmd.mean_x = '0; cmd.mean_y = '0; cmd.mean_z = '0;
        cmd.in_a = '0; cmd.in_b = '0; cmd.in_c = '0; cmd.in_d = '0;
        rsp.ready = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: identity, sign flip, saturation, zero norm, clamp and boundary
        send_item(qocm_pkg::OP_TO_CHART, one, 0, 0, 0, one, 0, 0, 0);
        send_item(qocm_pkg::OP_TO_CHART, one, 0, 0, 0, -one, 24'sd300000, -24'sd200000,
                  24'sd1);
        send_item(qocm_pkg::OP_TO_CHART, one, 0, 0, 0, 0, one, 0, 0);
        send_item(qocm_pkg::OP_TO_CHART, qocm_pkg::Q_MAX, qocm_pkg::Q_MAX, qocm_pkg::Q_MAX,
                  qocm_pkg::Q_MAX, qocm_pkg::Q_MAX, qocm_pkg::Q_MIN, qocm_pkg::Q_MAX,
                  qocm_pkg::Q_MIN);
        send_item(qocm_pkg::OP_TO_CHART, qocm_pkg::Q_MIN, qocm_pkg::Q_MIN, qocm_pkg::Q_MIN,
                  qocm_pkg::Q_MIN, qocm_pkg::Q_MIN, qocm_pkg::Q_MIN, qocm_pkg::Q_MIN,
                  qocm_pkg::Q_MIN);
        send_item(qocm_pkg::OP_TO_CHART, -24'sd1, 24'sd1, -24'sd1, 24'sd1, -24'sd1, -24'sd1,
                  24'sd1, 24'sd1);
        send_item(qocm_pkg::OP_TO_QUAT, one, 0, 0, 0, 0, 0, 0, qocm_pkg::Q_MAX);
        send_item(qocm_pkg::OP_TO_QUAT, one, 0, 0, 0, 24'sd2097152, 0, 0, 0);
        send_item(qocm_pkg::OP_TO_QUAT, one, 0, 0, 0, 24'sd2097153, 0, 0, 0);
        send_item(qocm_pkg::OP_TO_QUAT, one, 0, 0, 0, 24'sd2097152, 24'sd1, 0, 0);
        send_item(qocm_pkg::OP_TO_QUAT, one, 0, 0, 0, 0, -24'sd2097152, 0, 0);
        send_item(qocm_pkg::OP_TO_QUAT, one, 24'sd200, 0, 0, -24'sd2097153, 0, 0, 0);
        send_item(qocm_pkg::OP_TO_QUAT, one, 0, 0, 0, 24'sd2000000, 24'sd2000000, -24'sd1, 0);
        send_item(qocm_pkg::OP_TO_QUAT, qocm_pkg::Q_MAX, qocm_pkg::Q_MAX, qocm_pkg::Q_MAX,
                  qocm_pkg::Q_MAX, qocm_pkg::Q_MAX, qocm_pkg::Q_MAX, qocm_pkg::Q_MAX, 0);
        send_item(qocm_pkg::OP_TO_QUAT, qocm_pkg::Q_MIN, qocm_pkg::Q_MIN, qocm_pkg::Q_MIN,
                  qocm_pkg::Q_MIN, qocm_pkg::Q_MIN, qocm_pkg::Q_MIN, qocm_pkg::Q_MIN,
                  qocm_pkg::Q_MIN);
        send_item(qocm_pkg::OP_TO_QUAT, qocm_pkg::Q_MIN, qocm_pkg::Q_MAX, qocm_pkg::Q_MIN,
                  qocm_pkg::Q_MAX, 24'sd1, -24'sd1, 24'sd1, 0);
        send_item(qocm_pkg::OP_TO_QUAT, 24'sd741455, 24'sd741455, 0, 0, 24'sd700000,
                  24'sd700000, 24'sd700000, 0);

        // pause until every result is back
        drain();

        // hold the output side while the input keeps offering items
        fork
            begin
                hold_rsp = 1'b1;
                repeat (300) @(posedge clk);
                hold_rsp = 1'b0;
            end
            begin
                for (int i = 0; i < 100; i++)
                    send_random($urandom_range(1));
                cmd.valid <= 1'b0;
                @(posedge clk);
            end
        join

        for (int i = 0; i < 900; i++)
        begin
            steady = (i >= 300 && i < 450);
            send_random($urandom_range(1));
        end
        steady = 1'b0;

        drain();
        repeat (80) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

>>> sim.f
sv/qocm_pkg.sv
sv/qocm_in_if.sv
sv/qocm_out_if.sv
sv/quaternion_orthographic_chart_map_top.sv
tb/tb_quaternion_orthographic_chart_map_top.sv
